[hw/rtl/text_to_integer_parser_unit_macros.svh]
// assertion macros for the text to integer parser checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TEXT_TO_INTEGER_PARSER_UNIT_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define TTIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttip assertion failed");

// next-cycle implication
`define TTIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttip assertion failed");

`endif

[hw/rtl/ttip_pkg.sv]
// shared constants and helpers for the text to integer parser
// no dependencies
`default_nettype none

package ttip_pkg;

  localparam int DEF_VALUE_WIDTH = 64;
  localparam int DEF_MAX_LEN     = 4096;

  localparam int CHAR_W = 8;
  localparam int BASE_W = 6;

  // configuration register indexes
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGNED_INT  = 1'b1;

  localparam logic [BASE_W-1:0] BASE_LIMIT   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
  localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
  localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
  localparam logic [BASE_W-1:0] BASE_DETECT  = 6'd0;
  localparam logic [BASE_W-1:0] DIGIT_NONE   = 6'd63;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // digit value 0..35, DIGIT_NONE when not a digit in any base
  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end
    return d[BASE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/text_to_integer_parser_unit.sv]
// result path: a string's last character is held in the input register after its request
// is accepted, then its result is written to the result register
// throughput: one character per cycle; input register, parse logic with one
// value-by-base multiply-add, result register; a final character waits while the
// result register holds an untaken result
// reset: synchronous active-low rst_n clears parse state, configuration registers and valids
// depends on ttip_pkg
`default_nettype none

module text_to_integer_parser_unit
  import ttip_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_LEN     = DEF_MAX_LEN,
  localparam int POS_W      = $clog2(MAX_LEN + 1),
  localparam int OUT_BITS   = VALUE_WIDTH + POS_W + 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [CHAR_W-1:0] in_tdata,   // char_code
  input  wire logic              in_tlast,   // last_char
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // parsed_value, end_offset, digits_seen, zero pad
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [BASE_W-1:0] cfg_data
);

  localparam logic [2:0] PH_WS1    = 3'd0;
  localparam logic [2:0] PH_WS2    = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  logic [BASE_W-1:0]      number_base_r;
  logic                   int_mode_r;

  logic                   in_valid_r;
  logic [CHAR_W-1:0]      in_char_r;
  logic                   in_last_r;

  logic [2:0]             phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       end_r, end_nxt;
  logic                   any_r, any_nxt;
  logic                   neg_r, neg_nxt;
  logic                   stop_r, stop_nxt;

  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;

  logic                   advance;
  logic                   do_ws2, do_pre, do_zero, do_dig;
  logic [BASE_W-1:0]      base_sel, digit;
  logic [POS_W-1:0]       pos_after;
  logic [VALUE_WIDTH+BASE_W-1:0] prod;
  logic                   any_fin;
  logic [31:0]            low32;
  logic [VALUE_WIDTH-1:0] value_fin;
  logic [POS_W-1:0]       off_fin;

  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pos_after = (pos_r == MAX_POS) ? pos_r : pos_r + 1'b1;
  assign digit     = digit_of(in_char_r);
  assign prod      = acc_r * base_nxt;

  always_comb begin
    base_sel = int_mode_r ? BASE_DEC :
               ((number_base_r > BASE_LIMIT) ? BASE_LIMIT : number_base_r);
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    end_nxt   = end_r;
    any_nxt   = any_r;
    neg_nxt   = neg_r;
    stop_nxt  = stop_r;
    do_ws2    = 1'b0;
    do_pre    = 1'b0;
    do_zero   = 1'b0;
    do_dig    = 1'b0;
    if (!stop_r) begin
      unique case (phase_r)
        PH_WS1: begin
          if (!is_space(in_char_r)) begin
            if (int_mode_r) begin
              if (in_char_r == CH_MINUS) begin
                neg_nxt   = 1'b1;
                phase_nxt = PH_WS2;
              end else if (in_char_r == CH_PLUS) begin
                phase_nxt = PH_WS2;
              end else begin
                do_ws2 = 1'b1;
              end
            end else if (in_char_r == CH_PLUS) begin
              phase_nxt = PH_PREFIX;
            end else begin
              do_pre = 1'b1;
            end
          end
        end
        PH_WS2:    do_ws2  = 1'b1;
        PH_PREFIX: do_pre  = 1'b1;
        PH_ZERO:   do_zero = 1'b1;
        default:   do_dig  = 1'b1;
      endcase
    end
    if (do_ws2) begin
      if (is_space(in_char_r)) begin
        phase_nxt = PH_WS2;
      end else if (in_char_r == CH_PLUS) begin
        phase_nxt = PH_PREFIX;
      end else begin
        do_pre = 1'b1;
      end
    end
    if (do_pre) begin
      if ((base_sel == BASE_DETECT || base_sel == BASE_HEX) && in_char_r == CH_0) begin
        base_nxt  = base_sel;
        end_nxt   = pos_after;
        phase_nxt = PH_ZERO;
      end else begin
        base_nxt  = (base_sel == BASE_DETECT) ? BASE_DEC : base_sel;
        phase_nxt = PH_DIGITS;
        do_dig    = 1'b1;
      end
    end
    if (do_zero) begin
      phase_nxt = PH_DIGITS;
      if (in_char_r == CH_LX || in_char_r == CH_UX) begin
        base_nxt = BASE_HEX;
      end else begin
        if (base_r == BASE_DETECT) begin
          base_nxt = BASE_OCT;
        end
        any_nxt = 1'b1;
        do_dig  = 1'b1;
      end
    end
    if (do_dig) begin
      if (in_char_r == CH_NUL || digit >= base_nxt) begin
        stop_nxt = 1'b1;
      end else begin
        acc_nxt = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(digit);
        any_nxt = 1'b1;
        end_nxt = pos_after;
      end
    end
  end

  always_comb begin
    any_fin = any_nxt || (phase_nxt == PH_ZERO);
    low32   = neg_nxt ? (32'd0 - acc_nxt[31:0]) : acc_nxt[31:0];
    value_fin = int_mode_r ? VALUE_WIDTH'(low32) : acc_nxt;
    off_fin   = any_fin ? end_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_DETECT;
      int_mode_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUMBER_BASE: number_base_r <= cfg_data;
        REG_SIGNED_INT:  int_mode_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS1;
      acc_r   <= '0;
      base_r  <= BASE_DETECT;
      pos_r   <= '0;
      end_r   <= '0;
      any_r   <= 1'b0;
      neg_r   <= 1'b0;
      stop_r  <= 1'b0;
    end else if (advance) begin
      if (in_last_r) begin
        phase_r <= PH_WS1;
        acc_r   <= '0;
        base_r  <= BASE_DETECT;
        pos_r   <= '0;
        end_r   <= '0;
        any_r   <= 1'b0;
        neg_r   <= 1'b0;
        stop_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_after;
        end_r   <= end_nxt;
        any_r   <= any_nxt;
        neg_r   <= neg_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_data_r <= OUT_W'({any_fin, off_fin, value_fin});
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ttip_checker.sv]
// port-level checks for the text to integer parser, bound to the top level
// depends on ttip_pkg and text_to_integer_parser_unit_macros.svh
`default_nettype none

`include "text_to_integer_parser_unit_macros.svh"

module ttip_checker
  import ttip_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_LEN     = DEF_MAX_LEN,
  localparam int POS_W      = $clog2(MAX_LEN + 1),
  localparam int OUT_BITS   = VALUE_WIDTH + POS_W + 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_W-1:0]  out_tdata   // parsed_value, end_offset, digits_seen, zero pad
);

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  logic                   seen;
  logic [POS_W-1:0]       offset;
  logic [VALUE_WIDTH-1:0] value;

  assign value  = out_tdata[VALUE_WIDTH-1:0];
  assign offset = out_tdata[VALUE_WIDTH+POS_W-1:VALUE_WIDTH];
  assign seen   = out_tdata[VALUE_WIDTH+POS_W];

  // stalled result holds
  `TTIP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // no digit means zero value and zero offset
  `TTIP_ASSERT_SAME(a_no_digit_zero, out_tvalid && !seen, value == '0 && offset == '0)

  // offset never beyond the saturation point
  `TTIP_ASSERT_SAME(a_offset_bound, out_tvalid, offset <= MAX_POS)

  // with no result pending the input side never stalls
  `TTIP_ASSERT_SAME(a_ready_when_empty, !out_tvalid, in_tready)

endmodule

bind text_to_integer_parser_unit ttip_checker #(
  .VALUE_WIDTH(VALUE_WIDTH),
  .MAX_LEN(MAX_LEN)
) u_ttip_checker (.*);

`default_nettype wire
